@@ rtl/core/rtu_frx_pkg.sv @@
// Shared types and constants for the RTU frame receiver.
`default_nettype none
package rtu_frx_pkg;

  typedef enum logic [1:0] {
    CmdByte  = 2'd0,
    CmdPoll  = 2'd1,
    CmdRead  = 2'd2,
    CmdClear = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ModeIdle     = 2'd0,
    ModeRecv     = 2'd1,
    ModeComplete = 2'd2,
    ModeError    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusOverflow = 2'd1,
    StatusBadState = 2'd2
  } status_e;

  localparam logic RegCharGap  = 1'b0;
  localparam logic RegFrameGap = 1'b1;

  localparam int unsigned CharGapW  = 24;
  localparam int unsigned FrameGapW = 26;

  localparam logic [CharGapW-1:0]  CharGapReset  = 24'd750;
  localparam logic [FrameGapW-1:0] FrameGapReset = 26'd1750;

  localparam int unsigned MinFrameBytes = 4;

  typedef struct packed {
    logic [CharGapW-1:0]  char_gap_us;
    logic [FrameGapW-1:0] frame_gap_us;
  } cfg_t;

  // Result of one transaction as it leaves the control stage.
  typedef struct packed {
    status_e    status;
    logic       done;
    mode_e      mode;
    logic [8:0] length;
    logic       hit;
  } res_t;

endpackage
`default_nettype wire

@@ rtl/core/rtu_frame_receiver_top.sv @@
// Top level of the RTU frame receiver: config port, control, frame store, output register.
//
// Takes one transaction per cycle (byte, poll, read or clear) unless the output stalls,
// and returns one result for each via the control and output registers. Mode, fill count
// and last arrival time live in registers and are updated in the accept cycle; the frame
// bytes live in a MAX_FRAME x 8 synchronous memory written in the accept cycle and read
// through a registered port whose data joins the result in the output register. A write
// and a later read of the same entry are always separated by a poll, so no forwarding is
// needed. The store has no reset; entries beyond the fill count are never returned.
// Configuration registers sit at byte addresses 0 (character gap) and 4 (frame gap).
`default_nettype none
module rtu_frame_receiver_top #(
  parameter int unsigned MAX_FRAME = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic [31:0] now_us_i,
  input  wire logic [7:0]  read_index_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [1:0]  status_o,
  output logic             frame_done_o,
  output logic      [1:0]  receiver_state_o,
  output logic      [8:0]  frame_length_o,
  output logic      [7:0]  read_byte_o
);

  localparam int unsigned AddrW = $clog2(MAX_FRAME);
  localparam int unsigned CntW  = $clog2(MAX_FRAME + 1);

  rtu_frx_pkg::cfg_t cfg;
  rtu_frx_pkg::res_t res;
  logic              res_valid;
  logic              out_free;
  logic              we;
  logic [AddrW-1:0]  waddr;
  logic [7:0]        wdata;
  logic              re;
  logic [AddrW-1:0]  raddr;
  logic [7:0]        rdata;

  logic              out_valid_q;
  logic [1:0]        status_q;
  logic              done_q;
  logic [1:0]        state_q;
  logic [8:0]        length_q;
  logic [7:0]        byte_q;

  rtu_frx_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rtu_frx_ctrl #(
    .MaxFrame (MAX_FRAME),
    .AddrW    (AddrW),
    .CntW     (CntW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .data_byte_i  (data_byte_i),
    .now_us_i     (now_us_i),
    .read_index_i (read_index_i),
    .next_free_i  (out_free),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .we_o         (we),
    .waddr_o      (waddr),
    .wdata_o      (wdata),
    .re_o         (re),
    .raddr_o      (raddr)
  );

  rtu_frx_store #(
    .Depth (MAX_FRAME),
    .AddrW (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we & re),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res_valid;
    end
  end

  // Store read data stays put until the next acceptance, which needs this move.
  always_ff @(posedge clk_i) begin
    if (out_free && res_valid) begin
      status_q <= res.status;
      done_q   <= res.done;
      state_q  <= res.mode;
      length_q <= res.length;
      byte_q   <= res.hit ? rdata : 8'd0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign frame_done_o     = done_q;
  assign receiver_state_o = state_q;
  assign frame_length_o   = length_q;
  assign read_byte_o      = byte_q;

endmodule
`default_nettype wire

@@ rtl/core/rtu_frx_regs.sv @@
// APB configuration registers for the gap limits.
`default_nettype none
module rtu_frx_regs (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output rtu_frx_pkg::cfg_t      cfg_o
);

  rtu_frx_pkg::cfg_t cfg_q;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.char_gap_us  <= rtu_frx_pkg::CharGapReset;
      cfg_q.frame_gap_us <= rtu_frx_pkg::FrameGapReset;
    end else if (wr_en) begin
      if (paddr[2] == rtu_frx_pkg::RegCharGap) begin
        cfg_q.char_gap_us <= pwdata[rtu_frx_pkg::CharGapW-1:0];
      end else begin
        cfg_q.frame_gap_us <= pwdata[rtu_frx_pkg::FrameGapW-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == rtu_frx_pkg::RegCharGap) begin
      prdata = 32'(cfg_q.char_gap_us);
    end else begin
      prdata = 32'(cfg_q.frame_gap_us);
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

@@ rtl/core/rtu_frx_store.sv @@
// Frame byte store: one write port, one registered read port.
`default_nettype none
module rtu_frx_store #(
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = 8
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [7:0]       wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [7:0]       rdata_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ rtl/core/rtu_frx_ctrl.sv @@
// Receiver mode, fill count and arrival time; issues store accesses per transaction.
`default_nettype none
module rtu_frx_ctrl #(
  parameter int unsigned MaxFrame = 256,
  parameter int unsigned AddrW    = 8,
  parameter int unsigned CntW     = 9
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rtu_frx_pkg::cfg_t cfg_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        cmd_i,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic [31:0]       now_us_i,
  input  wire logic [7:0]        read_index_i,
  input  wire logic              next_free_i,
  output logic                   res_valid_o,
  output rtu_frx_pkg::res_t      res_o,
  output logic                   we_o,
  output logic      [AddrW-1:0]  waddr_o,
  output logic      [7:0]        wdata_o,
  output logic                   re_o,
  output logic      [AddrW-1:0]  raddr_o
);

  localparam int unsigned CmpW = (CntW > 8) ? CntW : 8;

  rtu_frx_pkg::mode_e mode_q, mode_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [31:0]        last_q, last_d;
  logic               res_valid_q;
  rtu_frx_pkg::res_t  res_q, res_d;
  logic [31:0]        gap;
  logic               accept;

  assign in_ready_o = !res_valid_q || next_free_i;
  assign accept     = in_valid_i && in_ready_o;
  assign gap        = now_us_i - last_q;

  always_comb begin
    mode_d       = mode_q;
    cnt_d        = cnt_q;
    last_d       = last_q;
    we_o         = 1'b0;
    waddr_o      = '0;
    res_d.status = rtu_frx_pkg::StatusOk;
    res_d.done   = 1'b0;
    res_d.length = '0;
    res_d.hit    = 1'b0;
    unique case (rtu_frx_pkg::cmd_e'(cmd_i))
      rtu_frx_pkg::CmdByte: begin
        unique case (mode_q)
          rtu_frx_pkg::ModeIdle: begin
            we_o   = 1'b1;
            cnt_d  = CntW'(1);
            last_d = now_us_i;
            mode_d = rtu_frx_pkg::ModeRecv;
          end
          rtu_frx_pkg::ModeRecv: begin
            last_d = now_us_i;
            // Late byte: restart the frame at this byte.
            if (gap > 32'(cfg_i.char_gap_us)) begin
              we_o  = 1'b1;
              cnt_d = CntW'(1);
            end else if (cnt_q < CntW'(MaxFrame)) begin
              we_o    = 1'b1;
              waddr_o = cnt_q[AddrW-1:0];
              cnt_d   = cnt_q + CntW'(1);
            end else begin
              mode_d       = rtu_frx_pkg::ModeError;
              res_d.status = rtu_frx_pkg::StatusOverflow;
            end
          end
          rtu_frx_pkg::ModeComplete: ;
          rtu_frx_pkg::ModeError: ;
        endcase
      end
      rtu_frx_pkg::CmdPoll: begin
        if (mode_q == rtu_frx_pkg::ModeComplete) begin
          res_d.done = 1'b1;
        end else if (mode_q == rtu_frx_pkg::ModeRecv &&
                     gap >= 32'(cfg_i.frame_gap_us)) begin
          if (cnt_q >= CntW'(rtu_frx_pkg::MinFrameBytes)) begin
            mode_d     = rtu_frx_pkg::ModeComplete;
            res_d.done = 1'b1;
          end else begin
            mode_d = rtu_frx_pkg::ModeError;
          end
        end
      end
      rtu_frx_pkg::CmdRead: begin
        if (mode_q == rtu_frx_pkg::ModeComplete) begin
          res_d.length = 9'(cnt_q);
          res_d.hit    = CmpW'(read_index_i) < CmpW'(cnt_q);
        end else begin
          res_d.status = rtu_frx_pkg::StatusBadState;
        end
      end
      rtu_frx_pkg::CmdClear: begin
        mode_d = rtu_frx_pkg::ModeIdle;
        cnt_d  = '0;
      end
    endcase
    res_d.mode = mode_d;
  end

  assign wdata_o = data_byte_i;
  assign re_o    = accept;
  assign raddr_o = AddrW'(read_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= rtu_frx_pkg::ModeIdle;
      cnt_q       <= '0;
      last_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        mode_q <= mode_d;
        cnt_q  <= cnt_d;
        last_q <= last_d;
      end
      if (in_ready_o) begin
        res_valid_q <= accept;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
`default_nettype wire

@@ rtl/core/rtu_frx_checker.sv @@
// Port-level assertions for the RTU frame receiver and their bind.
`default_nettype none
module rtu_frx_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [1:0]  status_o,
  input wire logic        frame_done_o,
  input wire logic [1:0]  receiver_state_o,
  input wire logic [8:0]  frame_length_o,
  input wire logic [7:0]  read_byte_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
      $stable(receiver_state_o) && $stable(frame_length_o) && $stable(read_byte_o))
    else $error("result changed while stalled");

  a_done_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_done_o |-> receiver_state_o == rtu_frx_pkg::ModeComplete)
    else $error("frame_done without complete mode");

  a_overflow_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == rtu_frx_pkg::StatusOverflow |->
      receiver_state_o == rtu_frx_pkg::ModeError && !frame_done_o)
    else $error("overflow without error mode");

  a_bad_read_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == rtu_frx_pkg::StatusBadState |->
      frame_length_o == 9'd0 && read_byte_o == 8'd0 &&
      receiver_state_o != rtu_frx_pkg::ModeComplete)
    else $error("rejected read returned data");

endmodule

bind rtu_frame_receiver_top rtu_frx_checker u_chk (.*);
`default_nettype wire
